FILE: rtl/rpe_pkg.sv
// Shared types, constants and the rounding function of the rotary position embedding unit.
// No dependencies; every other file in rtl/ imports this package.

package rpe_pkg;

    // Field widths of the beats.
    localparam int DATA_W  = 16;
    localparam int POS_W   = 8;
    localparam int IDX_W   = 6;
    localparam int HDIM_W  = 7;

    // Raw table address: position * half_dim + pair_index stays below 2^15.
    localparam int RAW_W   = POS_W + HDIM_W;

    // Arithmetic widths: Q1.15 coefficients, 32-bit products, 33-bit sums.
    localparam int FRAC_W  = 15;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int QUOT_W  = SUM_W + 1 - FRAC_W;
    localparam int ENTRY_W = 2 * DATA_W;

    localparam logic [FRAC_W-1:0]  ROUND_BIAS = FRAC_W'(1) << (FRAC_W - 1);
    localparam logic [DATA_W-1:0]  SAT_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0]  SAT_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration and parameter defaults.
    localparam logic [HDIM_W-1:0]  HDIM_RESET        = HDIM_W'(64);
    localparam int                 MAX_POSITIONS_DEF = 256;
    localparam int                 MAX_HALF_DIM_DEF  = 64;

    // Beat kinds.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_ROTATE = 1'b1;

    // One input beat as it moves through the address stages.
    typedef struct packed {
        logic              kind;
        logic              bad;
        logic [DATA_W-1:0] x_first;
        logic [DATA_W-1:0] x_second;
        logic [DATA_W-1:0] tsin;
        logic [DATA_W-1:0] tcos;
    } t_item;

    // One rotate beat with its table entry, after the table stage.
    typedef struct packed {
        logic              bad;
        logic [DATA_W-1:0] x_first;
        logic [DATA_W-1:0] x_second;
        logic [DATA_W-1:0] tsin;
        logic [DATA_W-1:0] tcos;
    } t_rot;

    // Round half up, arithmetic shift right by FRAC_W, saturate to DATA_W bits.
    function automatic logic [DATA_W-1:0] round_sat(input logic [SUM_W-1:0] sum);
        logic [SUM_W:0]       biased;
        logic [QUOT_W-1:0]    quot;
        logic [DATA_W-1:0]    res;
        biased = {sum[SUM_W-1], sum} + (SUM_W+1)'(ROUND_BIAS);
        quot   = biased[SUM_W:FRAC_W];
        if (quot[QUOT_W-1:DATA_W-1] == '0 || quot[QUOT_W-1:DATA_W-1] == '1) begin
            res = quot[DATA_W-1:0];
        end else if (quot[QUOT_W-1]) begin
            res = SAT_MIN;
        end else begin
            res = SAT_MAX;
        end
        return res;
    endfunction

endpackage

FILE: rtl/rpe_addr.sv
// Address stages: raw address, reciprocal quotient, and the remainder modulo the table depth.
// Depends on rpe_pkg.

module rpe_addr #(
    parameter int TABLE_DEPTH = rpe_pkg::MAX_POSITIONS_DEF * rpe_pkg::MAX_HALF_DIM_DEF,
    parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rpe_pkg::HDIM_W-1:0] i_half_dim,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rpe_pkg::t_item             i_item,
    input  logic [rpe_pkg::POS_W-1:0]  i_pos,
    input  logic [rpe_pkg::IDX_W-1:0]  i_idx,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rpe_pkg::t_item             o_item,
    output logic [ADDR_W-1:0]          o_addr
);
    import rpe_pkg::*;

    // Largest raw address that the field ranges allow.
    localparam int MAX_RAW  = (2**POS_W - 1) * (2**HDIM_W - 1) + (2**IDX_W - 1);
    localparam bit NEED_MOD = (TABLE_DEPTH <= MAX_RAW);

    logic               r_a_v, r_b_v, r_c_v;
    t_item              r_a_item, r_b_item, r_c_item;
    logic [RAW_W-1:0]   r_a_raw, r_b_raw, r_b_q;
    logic [ADDR_W-1:0]  r_c_addr;

    logic               w_a_rdy, w_b_rdy, w_c_rdy;
    t_item              n_a_item;
    logic [RAW_W-1:0]   n_a_raw;
    logic [RAW_W-1:0]   n_b_q;
    logic [ADDR_W-1:0]  n_c_addr;

    // Each stage takes a beat when it is empty or its beat moves on.
    assign w_c_rdy = !r_c_v || i_ready;
    assign w_b_rdy = !r_b_v || w_c_rdy;
    assign w_a_rdy = !r_a_v || w_b_rdy;
    assign o_ready = w_a_rdy;

    // Stage A: index check and raw address.
    always_comb begin
        n_a_item     = i_item;
        n_a_item.bad = ({1'b0, i_idx} >= i_half_dim);
        n_a_raw      = RAW_W'(RAW_W'(i_pos) * RAW_W'(i_half_dim)) + RAW_W'(i_idx);
    end

    // Stages B and C: quotient by reciprocal, then remainder.
    generate
        if (NEED_MOD) begin : g_mod
            localparam int             Q_SHIFT  = 2 * RAW_W;
            localparam int             M_W      = Q_SHIFT + 1;
            localparam int             MP_W     = RAW_W + M_W;
            localparam int             QD_W     = 2 * RAW_W;
            localparam longint         RECIP    =
                ((64'd1 << Q_SHIFT) + longint'(TABLE_DEPTH) - 1) / longint'(TABLE_DEPTH);
            localparam logic [M_W-1:0]   RECIP_K = M_W'(RECIP);
            localparam logic [RAW_W-1:0] DEPTH_K = RAW_W'(TABLE_DEPTH);

            logic [MP_W-1:0] w_prod;
            logic [QD_W-1:0] w_qd;
            logic [QD_W-1:0] w_rem;

            assign w_prod   = MP_W'(r_a_raw) * MP_W'(RECIP_K);
            assign n_b_q    = w_prod[Q_SHIFT +: RAW_W];
            assign w_qd     = QD_W'(r_b_q) * QD_W'(DEPTH_K);
            assign w_rem    = QD_W'(r_b_raw) - w_qd;
            assign n_c_addr = w_rem[ADDR_W-1:0];
        end else begin : g_nomod
            // The table covers every raw address, so it is used as is.
            assign n_b_q    = r_a_raw;
            assign n_c_addr = ADDR_W'(r_b_raw);
        end
    endgenerate

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (w_a_rdy) r_a_v <= i_valid;
            if (w_b_rdy) r_b_v <= r_a_v;
            if (w_c_rdy) r_c_v <= r_b_v;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_a_rdy) begin
            r_a_item <= n_a_item;
            r_a_raw  <= n_a_raw;
        end
        if (w_b_rdy) begin
            r_b_item <= r_a_item;
            r_b_raw  <= r_a_raw;
            r_b_q    <= n_b_q;
        end
        if (w_c_rdy) begin
            r_c_item <= r_b_item;
            r_c_addr <= n_c_addr;
        end
    end

    assign o_valid = r_c_v;
    assign o_item  = r_c_item;
    assign o_addr  = r_c_addr;

endmodule

FILE: rtl/rpe_table.sv
// Sine/cosine table stage: writes load beats, reads the entry for rotate beats.
// Depends on rpe_pkg.

module rpe_table #(
    parameter int TABLE_DEPTH = rpe_pkg::MAX_POSITIONS_DEF * rpe_pkg::MAX_HALF_DIM_DEF,
    parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rpe_pkg::t_item    i_item,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_valid,
    input  logic              i_ready,
    output rpe_pkg::t_rot     o_rot
);
    import rpe_pkg::*;

    logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd;
    logic               r_v;
    t_item              r_item;

    logic               w_rdy;
    logic               w_take;

    assign w_rdy   = !r_v || i_ready;
    assign w_take  = w_rdy && i_valid;
    assign o_ready = w_rdy;

    // Only rotate beats go on; a load beat ends here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid && (i_item.kind == KIND_ROTATE);
        end
    end

    // Table write for loads with a good index, registered read for rotates.
    always_ff @(posedge i_clk) begin
        if (w_take && i_item.kind == KIND_LOAD && !i_item.bad) begin
            r_mem[i_addr] <= {i_item.tsin, i_item.tcos};
        end
        if (w_take && i_item.kind == KIND_ROTATE) begin
            r_rd <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    // Sine sits in the upper half of an entry, cosine in the lower half.
    always_comb begin
        o_rot.bad      = r_item.bad;
        o_rot.x_first  = r_item.x_first;
        o_rot.x_second = r_item.x_second;
        o_rot.tsin     = r_rd[ENTRY_W-1:DATA_W];
        o_rot.tcos     = r_rd[DATA_W-1:0];
    end

    assign o_valid = r_v;

endmodule

FILE: rtl/rpe_rotate.sv
// Rotation stages: four products, then sums with rounding, saturation and the output register.
// Depends on rpe_pkg.

module rpe_rotate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  rpe_pkg::t_rot                     i_rot,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rpe_pkg::DATA_W-1:0] o_y_first,
    output logic signed [rpe_pkg::DATA_W-1:0] o_y_second,
    output logic                              o_index_error
);
    import rpe_pkg::*;

    logic                     r_e_v, r_f_v;
    logic                     r_e_bad;
    logic signed [PROD_W-1:0] r_p_fc, r_p_ss, r_p_fs, r_p_sc;
    logic [DATA_W-1:0]        r_y_first, r_y_second;
    logic                     r_err;

    logic                     w_e_rdy, w_f_rdy;
    logic [SUM_W-1:0]         w_sum_first, w_sum_second;

    assign w_f_rdy = !r_f_v || i_ready;
    assign w_e_rdy = !r_e_v || w_f_rdy;
    assign o_ready = w_e_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (w_e_rdy) r_e_v <= i_valid;
            if (w_f_rdy) r_f_v <= r_e_v;
        end
    end

    // Stage E: the four Q1.15 products.
    always_ff @(posedge i_clk) begin
        if (w_e_rdy) begin
            r_e_bad <= i_rot.bad;
            r_p_fc  <= $signed(i_rot.x_first)  * $signed(i_rot.tcos);
            r_p_ss  <= $signed(i_rot.x_second) * $signed(i_rot.tsin);
            r_p_fs  <= $signed(i_rot.x_first)  * $signed(i_rot.tsin);
            r_p_sc  <= $signed(i_rot.x_second) * $signed(i_rot.tcos);
        end
    end

    // Stage F: exact sums, one sign bit wider than the products.
    assign w_sum_first  = {r_p_fc[PROD_W-1], r_p_fc} - {r_p_ss[PROD_W-1], r_p_ss};
    assign w_sum_second = {r_p_fs[PROD_W-1], r_p_fs} + {r_p_sc[PROD_W-1], r_p_sc};

    // A bad pair index gives zeros with the error flag.
    always_ff @(posedge i_clk) begin
        if (w_f_rdy) begin
            r_err <= r_e_bad;
            if (r_e_bad) begin
                r_y_first  <= '0;
                r_y_second <= '0;
            end else begin
                r_y_first  <= round_sat(w_sum_first);
                r_y_second <= round_sat(w_sum_second);
            end
        end
    end

    assign o_valid       = r_f_v;
    assign o_y_first     = $signed(r_y_first);
    assign o_y_second    = $signed(r_y_second);
    assign o_index_error = r_err;

endmodule

FILE: rtl/rotary_position_embedding_unit.sv
// Top level of the interleaved rotary position embedding unit: configuration register and
// the address, table and rotation stages. Depends on rpe_pkg, rpe_addr, rpe_table, rpe_rotate.
//
//   Channel   Handshake                     Beat contents
//   -------   ---------------------------   -----------------------------------------------
//   input     i_in_valid / o_in_ready       kind, position, pair_index, x pair, sin, cos
//   output    o_out_valid / i_out_ready     y_first, y_second, index_error
//   config    i_cfg_wr_en                   i_cfg_wr_data = half_dim
//
// One beat enters per cycle while no stage is held by a stalled output.
// Load beats write the table in the table stage and give no result.
// The pipeline is three address stages, one table stage and two rotation stages; each stage
// holds its beat while the next one is full, so a stalled output fills the bubbles first.
// Reset clears the valid bits and sets half_dim to 64; table contents are undefined until
// written, and there is no clearing pass.

module rotary_position_embedding_unit #(
    parameter int MAX_POSITIONS = rpe_pkg::MAX_POSITIONS_DEF,
    parameter int MAX_HALF_DIM  = rpe_pkg::MAX_HALF_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rpe_pkg::HDIM_W-1:0]        i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic [rpe_pkg::POS_W-1:0]         i_position,
    input  logic [rpe_pkg::IDX_W-1:0]         i_pair_index,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_x_first,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_x_second,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_table_sin,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_table_cos,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [rpe_pkg::DATA_W-1:0] o_y_first,
    output logic signed [rpe_pkg::DATA_W-1:0] o_y_second,
    output logic                              o_index_error
);
    import rpe_pkg::*;

    localparam int TABLE_DEPTH = MAX_POSITIONS * MAX_HALF_DIM;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [HDIM_W-1:0] r_half_dim;
    t_item             w_in_item;

    logic              w_addr_valid, w_addr_ready;
    t_item             w_addr_item;
    logic [ADDR_W-1:0] w_addr;

    logic              w_rot_valid, w_rot_ready;
    t_rot              w_rot;

    // Pairs per position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_dim <= HDIM_RESET;
        end else if (i_cfg_wr_en) begin
            r_half_dim <= i_cfg_wr_data;
        end
    end

    // The index check is filled in by the first address stage.
    always_comb begin
        w_in_item.kind     = i_kind;
        w_in_item.bad      = 1'b0;
        w_in_item.x_first  = i_x_first;
        w_in_item.x_second = i_x_second;
        w_in_item.tsin     = i_table_sin;
        w_in_item.tcos     = i_table_cos;
    end

    rpe_addr #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_addr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_half_dim (r_half_dim),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_item     (w_in_item),
        .i_pos      (i_position),
        .i_idx      (i_pair_index),
        .o_valid    (w_addr_valid),
        .i_ready    (w_addr_ready),
        .o_item     (w_addr_item),
        .o_addr     (w_addr)
    );

    rpe_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_addr_valid),
        .o_ready (w_addr_ready),
        .i_item  (w_addr_item),
        .i_addr  (w_addr),
        .o_valid (w_rot_valid),
        .i_ready (w_rot_ready),
        .o_rot   (w_rot)
    );

    rpe_rotate u_rotate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_rot_valid),
        .o_ready       (w_rot_ready),
        .i_rot         (w_rot),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_y_first     (o_y_first),
        .o_y_second    (o_y_second),
        .o_index_error (o_index_error)
    );

endmodule

FILE: verif/rotary_position_embedding_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rotary_position_embedding_unit: load and rotate beats are driven,
// each rotated pair is predicted in-line and compared with the output stream. Depends on rpe_pkg.

module rotary_position_embedding_unit_tb;
    import rpe_pkg::*;

    localparam int TABLE_DEPTH  = MAX_POSITIONS_DEF * MAX_HALF_DIM_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PCT     = 34;
    localparam int HOLD_CYCLES  = 300;

    // One expected output beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] y_first;
        logic signed [DATA_W-1:0] y_second;
        logic                     index_error;
    } rotated_pair_t;

    // A table slot that holds a written entry under the current half_dim.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [IDX_W-1:0] pair_index;
    } table_slot_t;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [HDIM_W-1:0]        i_cfg_wr_data = '0;
    logic                     i_in_valid    = 1'b0;
    logic                     i_kind        = KIND_LOAD;
    logic [POS_W-1:0]         i_position    = '0;
    logic [IDX_W-1:0]         i_pair_index  = '0;
    logic signed [DATA_W-1:0] i_x_first     = '0;
    logic signed [DATA_W-1:0] i_x_second    = '0;
    logic signed [DATA_W-1:0] i_table_sin   = '0;
    logic signed [DATA_W-1:0] i_table_cos   = '0;
    logic                     i_out_ready   = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_y_first;
    logic signed [DATA_W-1:0] o_y_second;
    logic                     o_index_error;

    rotary_position_embedding_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_pair_index  (i_pair_index),
        .i_x_first     (i_x_first),
        .i_x_second    (i_x_second),
        .i_table_sin   (i_table_sin),
        .i_table_cos   (i_table_cos),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_y_first     (o_y_first),
        .o_y_second    (o_y_second),
        .o_index_error (o_index_error)
    );

    // Shadow copy of the sine/cosine table and the half_dim register.
    logic [ENTRY_W-1:0] sincos_mem [TABLE_DEPTH];
    bit                 entry_written [TABLE_DEPTH];
    int unsigned        half_dim_now = 64;
    table_slot_t        loaded_slots [$];
    rotated_pair_t      pending_rotations [$];

    bit idle_on           = 1'b1;
    int sink_hold_cycles  = 0;
    int mismatch_count    = 0;
    int cycle_count       = 0;
    int load_count        = 0;
    int rotate_count      = 0;
    int bad_index_count   = 0;
    int result_count      = 0;
    int setting_count     = 0;

    // Free-running clock, 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_rotations.size());
            $display("** rotary_position_embedding_unit: FAILED **");
            $finish;
        end
    end

    // Round half up, shift right by 15 and clamp to the signed 16-bit range.
    function automatic logic signed [DATA_W-1:0] round_to_q15(input longint sum);
        longint q;
        q = (sum + 16384) >>> FRAC_W;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[DATA_W-1:0];
    endfunction

    function automatic int unsigned table_address(input logic [POS_W-1:0] pos,
                                                  input logic [IDX_W-1:0] idx);
        return (pos * half_dim_now + idx) % TABLE_DEPTH;
    endfunction

    // A load with a column at or past half_dim leaves the table untouched.
    function automatic void store_sincos(input logic [POS_W-1:0] pos,
                                         input logic [IDX_W-1:0] idx,
                                         input logic signed [DATA_W-1:0] s, c);
        int unsigned addr;
        if (idx >= half_dim_now) begin
            return;
        end
        addr = table_address(pos, idx);
        sincos_mem[addr] = {s, c};
        entry_written[addr] = 1'b1;
        loaded_slots.push_back('{position: pos, pair_index: idx});
    endfunction

    // Expected output of one rotate beat.
    function automatic rotated_pair_t rotate_pair(input logic [POS_W-1:0] pos,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic signed [DATA_W-1:0] xf, xs);
        rotated_pair_t      r;
        logic [ENTRY_W-1:0] entry;
        longint             a, b, sn, cs;
        r = '0;
        if (idx >= half_dim_now) begin
            r.index_error = 1'b1;
            return r;
        end
        entry = sincos_mem[table_address(pos, idx)];
        sn = $signed(entry[ENTRY_W-1:DATA_W]);
        cs = $signed(entry[DATA_W-1:0]);
        a  = xf;
        b  = xs;
        r.y_first  = round_to_q15(a * cs - b * sn);
        r.y_second = round_to_q15(a * sn + b * cs);
        return r;
    endfunction

    // Random sample, with the two extremes of the range weighted up.
    function automatic logic signed [DATA_W-1:0] rand_sample();
        case ($urandom_range(15))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Offer one beat, after a random gap, and hold it until it is taken.
    task automatic send_beat(input logic k, input logic [POS_W-1:0] pos,
                             input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] xf, xs, s, c);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= k;
        i_position   <= pos;
        i_pair_index <= idx;
        i_x_first    <= xf;
        i_x_second   <= xs;
        i_table_sin  <= s;
        i_table_cos  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        if (k == KIND_LOAD) begin
            store_sincos(pos, idx, s, c);
            load_count++;
        end else begin
            pending_rotations.push_back(rotate_pair(pos, idx, xf, xs));
            rotate_count++;
            if (idx >= half_dim_now) bad_index_count++;
        end
    endtask

    // Stop offering beats and wait until every expected result has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rotations.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half_dim(input int unsigned value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= HDIM_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        half_dim_now = value;
        loaded_slots.delete();
        setting_count++;
        @(posedge i_clk);
    endtask

    // Mostly loads followed by rotates of loaded entries, with some bad columns mixed in.
    task automatic send_random_beats(input int count);
        int unsigned      pick, good_span;
        logic [POS_W-1:0] pos;
        logic [IDX_W-1:0] idx;
        table_slot_t      slot;
        good_span = (half_dim_now > 64) ? 64 : half_dim_now;
        repeat (count) begin
            pick = $urandom_range(99);
            pos  = POS_W'($urandom);
            idx  = IDX_W'($urandom);
            if (pick >= 90 && good_span < 64) begin
                idx = IDX_W'($urandom_range(63, good_span));
                send_beat(KIND_ROTATE, pos, idx, rand_sample(), rand_sample(),
                          rand_sample(), rand_sample());
            end else if (pick >= 90 && entry_written[table_address(pos, idx)]) begin
                // Any written entry, possibly from an earlier half_dim setting.
                send_beat(KIND_ROTATE, pos, idx, rand_sample(), rand_sample(),
                          rand_sample(), rand_sample());
            end else if (pick >= 35 && pick < 90 && loaded_slots.size() != 0) begin
                slot = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
                send_beat(KIND_ROTATE, slot.position, slot.pair_index, rand_sample(),
                          rand_sample(), rand_sample(), rand_sample());
            end else begin
                if (good_span != 0 && $urandom_range(9) != 0) begin
                    idx = IDX_W'($urandom_range(good_span - 1));
                end
                send_beat(KIND_LOAD, pos, idx, rand_sample(), rand_sample(),
                          rand_sample(), rand_sample());
            end
        end
    endtask

    // Output side: check each taken beat against the oldest expectation, then stall at random.
    always @(posedge i_clk) begin : collect_results
        rotated_pair_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (pending_rotations.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result beat: y_first=%0d y_second=%0d error=%0b",
                             o_y_first, o_y_second, o_index_error);
                end
            end else begin
                want = pending_rotations.pop_front();
                if (o_y_first !== want.y_first || o_y_second !== want.y_second ||
                    o_index_error !== want.index_error) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display(
                            "Mismatch, cycle %0d: expected %0d %0d e=%0b, got %0d %0d e=%0b",
                            cycle_count, want.y_first, want.y_second, want.index_error,
                            o_y_first, o_y_second, o_index_error);
                    end
                end
            end
        end
        if (sink_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            sink_hold_cycles--;
        end else begin
            i_out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Reset setting: corner values, saturation both ways, rounding ties, overwrite.
    task automatic test_reset_setting_corners();
        send_beat(KIND_LOAD,     0,  0, 0, 0, 0, 32767);
        send_beat(KIND_ROTATE,   0,  0, 32767, -32768, 0, 0);
        send_beat(KIND_LOAD,   255, 63, 0, 0, -32768, -32768);
        send_beat(KIND_ROTATE, 255, 63, -32768, -32768, 0, 0);
        send_beat(KIND_ROTATE, 255, 63, -32768, 32767, 0, 0);
        send_beat(KIND_LOAD,   128, 32, 0, 0, 32767, -32768);
        send_beat(KIND_ROTATE, 128, 32, 32767, 32767, 0, 0);
        send_beat(KIND_ROTATE, 128, 32, -32768, -32768, 0, 0);
        send_beat(KIND_LOAD,     1,  1, 0, 0, 23170, 23170);
        send_beat(KIND_ROTATE,   1,  1, 12345, -6789, 0, 0);
        send_beat(KIND_LOAD,    85, 42, 0, 0, 0, 1);
        send_beat(KIND_ROTATE,  85, 42, 16384, -16384, 0, 0);
        send_beat(KIND_ROTATE,  85, 42, -16384, 16384, 0, 0);
        send_beat(KIND_LOAD,     0,  0, 0, 0, -32768, 0);
        send_beat(KIND_ROTATE,   0,  0, 32767, 32767, 0, 0);
        send_beat(KIND_ROTATE,   0,  0, 0, 0, 0, 0);
    endtask

    // Small half_dim: bad columns on rotate, and a bad load landing on a valid entry's address.
    task automatic test_small_dim_bad_index();
        write_half_dim(13);
        send_beat(KIND_LOAD,     1,  7, 0, 0, 1000, 2000);
        send_beat(KIND_LOAD,     0, 20, 0, 0, -1, -1);
        send_beat(KIND_ROTATE,   1,  7, 300, 400, 0, 0);
        send_beat(KIND_ROTATE,   9, 13, 500, 500, 0, 0);
        send_beat(KIND_ROTATE, 255, 63, -32768, 32767, 0, 0);
        send_beat(KIND_LOAD,   255, 12, 0, 0, -20000, 30000);
        send_beat(KIND_ROTATE, 255, 12, -32768, 32767, 0, 0);
    endtask

    // Zero half_dim: every column is bad and loads write nothing.
    task automatic test_zero_half_dim();
        write_half_dim(0);
        send_beat(KIND_LOAD,     3,  0, 0, 0, 111, 222);
        send_beat(KIND_ROTATE,   3,  0, 1234, 4321, 0, 0);
        send_beat(KIND_ROTATE,   0,  0, -1, -1, 0, 0);
        send_beat(KIND_ROTATE, 255, 63, 32767, -32768, 0, 0);
    endtask

    // Largest half_dim: addresses wrap around the table and alias other slots.
    task automatic test_address_wrap();
        write_half_dim(127);
        send_beat(KIND_LOAD,   200, 10, 0, 0, 9000, -15000);
        send_beat(KIND_ROTATE,  71,  9, 20000, -7000, 0, 0);
        send_beat(KIND_LOAD,   255, 63, 0, 0, 32767, 32767);
        send_beat(KIND_ROTATE, 255, 63, 32767, 32767, 0, 0);
        send_beat(KIND_LOAD,     0,  0, 0, 0, -5, 7);
        send_beat(KIND_ROTATE,   0,  0, -32768, -32768, 0, 0);
    endtask

    // One pair per position.
    task automatic test_single_pair();
        write_half_dim(1);
        send_beat(KIND_LOAD,    77,  0, 0, 0, 12000, -25000);
        send_beat(KIND_ROTATE,  77,  0, 31000, -31000, 0, 0);
        send_beat(KIND_ROTATE,  77,  1, 31000, -31000, 0, 0);
        send_beat(KIND_ROTATE,  77, 63, 1, 1, 0, 0);
    endtask

    // Random traffic over a sequence of half_dim settings.
    task automatic test_random_settings();
        int unsigned plan [7];
        int          counts [7];
        plan   = '{64, 1, 127, 0, 0, 0, 64};
        counts = '{130, 90, 130, 130, 30, 100, 73};
        plan[3] = $urandom_range(126, 2);
        plan[5] = $urandom_range(63, 2);
        foreach (plan[i]) begin
            write_half_dim(plan[i]);
            send_random_beats(counts[i]);
        end
    endtask

    // Receiver holds off long enough for the pipeline to fill, then the sender pauses.
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        sink_hold_cycles = HOLD_CYCLES;
        send_random_beats(60);
        idle_on = 1'b1;
        wait_drained();
        send_random_beats(20);
    endtask

    // A long stretch with no idling on either side.
    task automatic test_unbroken_stream();
        idle_on = 1'b0;
        send_random_beats(150);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_setting_corners();
        test_small_dim_bad_index();
        test_zero_half_dim();
        test_address_wrap();
        test_single_pair();
        test_random_settings();
        test_output_backpressure();
        test_unbroken_stream();
        wait_drained();
        $display("Sent %0d load beats and %0d rotate beats (%0d with a bad pair index) over %0d",
                 load_count, rotate_count, bad_index_count, setting_count);
        $display("half_dim writes; %0d result beats checked, %0d mismatches.",
                 result_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** rotary_position_embedding_unit: PASSED **");
        end else begin
            $display("** rotary_position_embedding_unit: FAILED **");
        end
        $finish;
    end

endmodule
